>>> hw/rtl/tdle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdle_pkg;

  localparam int PENDING_DEPTH = 16;
  localparam int ACTIVE_DEPTH  = 16;
  localparam int HISTORY_DEPTH = 16;

  localparam int PEND_AW = $clog2(PENDING_DEPTH);
  localparam int PEND_CW = $clog2(PENDING_DEPTH + 1);
  localparam int ACT_AW  = $clog2(ACTIVE_DEPTH);
  localparam int ACT_CW  = $clog2(ACTIVE_DEPTH + 1);
  localparam int HIST_AW = $clog2(HISTORY_DEPTH);
  localparam int HIST_CW = $clog2(HISTORY_DEPTH + 1);
  localparam int CNT_W   = $clog2(ACTIVE_DEPTH);

  localparam int ID_W     = 16;
  localparam int DUE_W    = 16;
  localparam int POS_W    = 4;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  localparam int IN_FIELDS_W  = ID_W + DUE_W + POS_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = ID_W + DUE_W + 3 * COUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQUEUE      = 3'd0,
    ACT_PROMOTE      = 3'd1,
    ACT_SORT         = 3'd2,
    ACT_COMPLETE     = 3'd3,
    ACT_READ_ACTIVE  = 3'd4,
    ACT_READ_HISTORY = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 3'd0,
    STATUS_PEND_EMPTY = 3'd1,
    STATUS_PEND_FULL  = 3'd2,
    STATUS_ACT_EMPTY  = 3'd3,
    STATUS_ACT_FULL   = 3'd4,
    STATUS_NOT_FOUND  = 3'd5,
    STATUS_BAD_POS    = 3'd6,
    STATUS_HIST_FULL  = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD  = 3'd0,
    CELL_PUSH  = 3'd1,
    CELL_MATCH = 3'd2,
    CELL_SCAN  = 3'd3,
    CELL_SORT  = 3'd4,
    CELL_PULL  = 3'd5
  } cell_op_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [DUE_W-1:0] due;
  } record_t;

  typedef struct packed {
    logic    seen;
    record_t carry;
  } scan_t;

  typedef struct packed {
    logic in_use;
    logic pair_lo;
    logic pair_hi;
  } cell_sel_t;

  typedef struct packed {
    cell_op_t          op;
    logic [ID_W-1:0]   key;
    record_t           rec_in;
    logic [ACT_CW-1:0] fill;
    logic              phase;
  } chain_ctrl_t;

  typedef struct packed {
    logic    found;
    record_t hit;
  } chain_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/tdle_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module tdle_cell
  import tdle_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  cell_op_t        op,
  input  logic [ID_W-1:0] key,
  input  cell_sel_t       sel,
  input  record_t         left_rec,
  input  record_t         right_rec,
  input  logic            left_gt,
  input  scan_t           left_scan,
  output record_t         rec,
  output logic            gt,
  output scan_t           scan_out
);

  record_t rec_r, rec_nxt;
  record_t carry_r, carry_nxt;
  logic    match_r, match_nxt;
  logic    seen_r, seen_nxt;

  assign rec            = rec_r;
  assign gt             = rec_r.due > right_rec.due;
  assign scan_out.seen  = seen_r | match_r;
  assign scan_out.carry = seen_r ? carry_r : rec_r;

  always_comb begin
    rec_nxt   = rec_r;
    carry_nxt = carry_r;
    match_nxt = match_r;
    seen_nxt  = seen_r;
    case (op)
      CELL_PUSH: begin
        rec_nxt = left_rec;
      end
      CELL_MATCH: begin
        match_nxt = sel.in_use && (rec_r.id == key);
        seen_nxt  = 1'b0;
      end
      CELL_SCAN: begin
        seen_nxt  = left_scan.seen;
        carry_nxt = left_scan.carry;
      end
      CELL_SORT: begin
        if (sel.pair_hi && gt) begin
          rec_nxt = right_rec;
        end else if (sel.pair_lo && left_gt) begin
          rec_nxt = left_rec;
        end
      end
      CELL_PULL: begin
        if (seen_r | match_r) begin
          rec_nxt = right_rec;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r   <= rec_nxt;
    carry_r <= carry_nxt;
    if (!rst_n) begin
      match_r <= 1'b0;
      seen_r  <= 1'b0;
    end else begin
      match_r <= match_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tdle_chain.sv
`timescale 1ns / 1ps
`default_nettype none

module tdle_chain
  import tdle_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  chain_ctrl_t       ctrl,
  input  logic [ACT_AW-1:0] rd_idx,
  output record_t           rd_rec,
  output chain_stat_t       stat
);

  localparam int LAST = ACTIVE_DEPTH - 1;

  record_t                 recs  [ACTIVE_DEPTH];
  logic                    gts   [ACTIVE_DEPTH];
  scan_t                   scans [ACTIVE_DEPTH];
  logic [ACTIVE_DEPTH-1:0] pair_en;

  logic    found_r, found_nxt;
  record_t hit_r, hit_nxt;

  genvar i;
  generate
    for (i = 0; i < ACTIVE_DEPTH; i++) begin : g_cell
      record_t   left_rec;
      record_t   right_rec;
      logic      left_gt;
      scan_t     left_scan;
      logic      pair_lo;
      logic      in_use;
      cell_sel_t sel;

      assign pair_en[i] = (ctrl.phase == 1'(i % 2)) &&
                          ((32'(i) + 32'd1) < 32'(ctrl.fill));
      assign in_use     = 32'(i) < 32'(ctrl.fill);
      assign sel        = {in_use, pair_lo, pair_en[i]};

      if (i == 0) begin : g_head
        assign left_rec  = ctrl.rec_in;
        assign left_gt   = 1'b0;
        assign left_scan = '0;
        assign pair_lo   = 1'b0;
      end else begin : g_body
        assign left_rec  = recs[i-1];
        assign left_gt   = gts[i-1];
        assign left_scan = scans[i-1];
        assign pair_lo   = pair_en[i-1];
      end

      if (i == LAST) begin : g_tail
        assign right_rec = '0;
      end else begin : g_link
        assign right_rec = recs[i+1];
      end

      tdle_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (ctrl.op),
        .key       (ctrl.key),
        .sel       (sel),
        .left_rec  (left_rec),
        .right_rec (right_rec),
        .left_gt   (left_gt),
        .left_scan (left_scan),
        .rec       (recs[i]),
        .gt        (gts[i]),
        .scan_out  (scans[i])
      );
    end
  endgenerate

  // end of the chain collects the first match after one hop per cell
  always_comb begin
    found_nxt = found_r;
    hit_nxt   = hit_r;
    case (ctrl.op)
      CELL_MATCH: begin
        found_nxt = 1'b0;
      end
      CELL_SCAN: begin
        found_nxt = scans[LAST].seen;
        hit_nxt   = scans[LAST].carry;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  assign rd_rec     = recs[rd_idx];
  assign stat.found = found_r;
  assign stat.hit   = hit_r;

endmodule

`default_nettype wire

>>> hw/rtl/task_deadline_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  tdata                                   tuser
// in_*      slave      task_id, due_days, position             action
// out_*     master     result_id, result_due, pending_count,   status
//                      active_count, history_count
//
// enqueue, promote, reads, unused codes and complete on an empty list: result loaded at acceptance
// sort and other completes: one compare-exchange round or one search hop per cycle along the
// active cell chain, between the accept cycle and a finish cycle
// reset clears state, fills, pointers and flags; store entries stay undefined, no clearing pass
// a finished result waits in the output register; a new transfer is taken while it
// is empty or being taken, and a long action waits in its finish cycle for the same

module task_deadline_list_engine
  import tdle_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // task_id, due_days, position
  input  logic [ACTION_W-1:0]    in_tuser,   // action
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // result_id, result_due, pending_count,
                                             // active_count, history_count
  output logic [STATUS_W-1:0]    out_tuser   // status
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_SORT   = 4'b0100,
    ST_FINISH = 4'b1000
  } seq_state_t;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ACTIVE_DEPTH - 1);

  seq_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  action_t            act_r, act_nxt;
  logic [PEND_AW-1:0] head_r, head_nxt;
  logic [PEND_AW-1:0] tail_r, tail_nxt;
  logic [PEND_CW-1:0] p_fill_r, p_fill_nxt;
  logic [ACT_CW-1:0]  a_fill_r, a_fill_nxt;
  logic [HIST_CW-1:0] h_fill_r, h_fill_nxt;

  record_t            pend_r [PENDING_DEPTH];
  logic [ID_W-1:0]    hist_r [HISTORY_DEPTH];

  logic               out_valid_r;
  status_t            out_status_r;
  logic [ID_W-1:0]    out_id_r;
  logic [DUE_W-1:0]   out_due_r;

  action_t            in_action;
  logic [ID_W-1:0]    in_id;
  logic [DUE_W-1:0]   in_due;
  logic [POS_W-1:0]   in_pos;
  logic               accept;
  logic               out_free;
  logic               out_load;
  logic               pend_we;
  logic               hist_we;
  logic               pull_done;
  status_t            st;
  logic [ID_W-1:0]    rid;
  logic [DUE_W-1:0]   rdue;
  logic [HIST_AW-1:0] hist_rd_idx;
  record_t            pend_head;
  record_t            act_rd;
  chain_ctrl_t        ctrl;
  chain_stat_t        cstat;

  assign in_action   = action_t'(in_tuser);
  assign in_id       = in_tdata[ID_W-1:0];
  assign in_due      = in_tdata[ID_W+DUE_W-1:ID_W];
  assign in_pos      = in_tdata[IN_FIELDS_W-1:ID_W+DUE_W];
  assign out_free    = !out_valid_r || out_tready;
  assign in_tready   = (state_r == ST_IDLE) && out_free;
  assign accept      = in_tvalid && in_tready;
  assign hist_rd_idx = HIST_AW'(32'(h_fill_r) - 32'd1 - 32'(in_pos));
  assign pend_head   = pend_r[head_r];

  tdle_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .rd_idx (ACT_AW'(in_pos)),
    .rd_rec (act_rd),
    .stat   (cstat)
  );

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    act_nxt     = act_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    p_fill_nxt  = p_fill_r;
    a_fill_nxt  = a_fill_r;
    h_fill_nxt  = h_fill_r;
    out_load    = 1'b0;
    pend_we     = 1'b0;
    hist_we     = 1'b0;
    pull_done   = 1'b0;
    st          = STATUS_OK;
    rid         = '0;
    rdue        = '0;
    ctrl.op     = CELL_HOLD;
    ctrl.key    = in_id;
    ctrl.rec_in = pend_head;
    ctrl.fill   = a_fill_r;
    ctrl.phase  = cnt_r[0];
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          act_nxt = in_action;
          case (in_action)
            ACT_ENQUEUE: begin
              out_load = 1'b1;
              if (p_fill_r == PEND_CW'(PENDING_DEPTH)) begin
                st = STATUS_PEND_FULL;
              end else begin
                pend_we    = 1'b1;
                tail_nxt   = (tail_r == PEND_AW'(PENDING_DEPTH - 1)) ? '0 :
                             tail_r + PEND_AW'(1);
                p_fill_nxt = p_fill_r + PEND_CW'(1);
                rid        = in_id;
                rdue       = in_due;
              end
            end
            ACT_PROMOTE: begin
              out_load = 1'b1;
              if (p_fill_r == '0) begin
                st = STATUS_PEND_EMPTY;
              end else if (a_fill_r == ACT_CW'(ACTIVE_DEPTH)) begin
                st = STATUS_ACT_FULL;
              end else begin
                ctrl.op    = CELL_PUSH;
                head_nxt   = (head_r == PEND_AW'(PENDING_DEPTH - 1)) ? '0 :
                             head_r + PEND_AW'(1);
                p_fill_nxt = p_fill_r - PEND_CW'(1);
                a_fill_nxt = a_fill_r + ACT_CW'(1);
                rid        = pend_head.id;
                rdue       = pend_head.due;
              end
            end
            ACT_SORT: begin
              state_nxt = ST_SORT;
              cnt_nxt   = '0;
            end
            ACT_COMPLETE: begin
              if (a_fill_r == '0) begin
                out_load = 1'b1;
                st       = STATUS_ACT_EMPTY;
              end else begin
                ctrl.op   = CELL_MATCH;
                state_nxt = ST_SCAN;
                cnt_nxt   = '0;
              end
            end
            ACT_READ_ACTIVE: begin
              out_load = 1'b1;
              if (32'(in_pos) >= 32'(a_fill_r)) begin
                st = STATUS_BAD_POS;
              end else begin
                rid  = act_rd.id;
                rdue = act_rd.due;
              end
            end
            ACT_READ_HISTORY: begin
              out_load = 1'b1;
              if (32'(in_pos) >= 32'(h_fill_r)) begin
                st = STATUS_BAD_POS;
              end else begin
                rid = hist_r[hist_rd_idx];
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        ctrl.op = CELL_SCAN;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SORT: begin
        ctrl.op = CELL_SORT;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (act_r == ACT_COMPLETE) begin
            if (!cstat.found) begin
              st = STATUS_NOT_FOUND;
            end else if (h_fill_r == HIST_CW'(HISTORY_DEPTH)) begin
              st = STATUS_HIST_FULL;
            end else begin
              ctrl.op    = CELL_PULL;
              hist_we    = 1'b1;
              pull_done  = 1'b1;
              a_fill_nxt = a_fill_r - ACT_CW'(1);
              h_fill_nxt = h_fill_r + HIST_CW'(1);
              rid        = cstat.hit.id;
              rdue       = cstat.hit.due;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    if (pend_we) begin
      pend_r[tail_r] <= '{id: in_id, due: in_due};
    end
    if (hist_we) begin
      hist_r[HIST_AW'(h_fill_r)] <= cstat.hit.id;
    end
    if (out_load) begin
      out_status_r <= st;
      out_id_r     <= rid;
      out_due_r    <= rdue;
    end
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      p_fill_r    <= '0;
      a_fill_r    <= '0;
      h_fill_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      p_fill_r <= p_fill_nxt;
      a_fill_r <= a_fill_nxt;
      h_fill_r <= h_fill_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // counts only move on a result load, so the fills match the held result
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_TDATA_W'({COUNT_W'(32'(h_fill_r)), COUNT_W'(32'(a_fill_r)),
                                    COUNT_W'(32'(p_fill_r)), out_due_r, out_id_r});

  a_fills_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(p_fill_r) <= PENDING_DEPTH) && (32'(a_fill_r) <= ACTIVE_DEPTH) &&
    (32'(h_fill_r) <= HISTORY_DEPTH))
    else $error("store fill beyond depth");

  a_ring_pointers: assert property (@(posedge clk) disable iff (!rst_n)
    32'(tail_r) == ((32'(head_r) + 32'(p_fill_r)) % PENDING_DEPTH))
    else $error("pending ring pointers out of step with fill");

  a_complete_moves_one: assert property (@(posedge clk) disable iff (!rst_n)
    pull_done |=> (a_fill_r == $past(a_fill_r) - ACT_CW'(1)) &&
                  (h_fill_r == $past(h_fill_r) + HIST_CW'(1)))
    else $error("complete did not move exactly one record");

  a_load_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !accept) |-> (state_r == ST_FINISH))
    else $error("result loaded outside a transfer or finish cycle");

endmodule

`default_nettype wire

>>> dv/task_deadline_list_engine_test.sv
`timescale 1ns / 1ps

module task_deadline_list_engine_test;
  import tdle_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;
  localparam int RANDOM_ITEMS = 850;
  localparam int STALL_LIMIT  = 2000;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [DUE_W-1:0]    due;
    logic [COUNT_W-1:0]  pend_cnt;
    logic [COUNT_W-1:0]  act_cnt;
    logic [COUNT_W-1:0]  hist_cnt;
  } reply_t;

  class deadline_scoreboard;
    logic [ID_W-1:0]  queue_id[PENDING_DEPTH];
    logic [DUE_W-1:0] queue_due[PENDING_DEPTH];
    int               queue_head;
    int               queue_fill;
    logic [ID_W-1:0]  list_id[ACTIVE_DEPTH];
    logic [DUE_W-1:0] list_due[ACTIVE_DEPTH];
    int               list_fill;
    logic [ID_W-1:0]  done_id[HISTORY_DEPTH];
    int               done_fill;
    reply_t           awaited_replies[$];
    int               errors;

    function new();
      queue_head = 0;
      queue_fill = 0;
      list_fill  = 0;
      done_fill  = 0;
      errors     = 0;
    endfunction

    function void sort_by_deadline();
      int limit;
      int i;
      bit swapped;
      logic [ID_W-1:0]  tid;
      logic [DUE_W-1:0] tdue;
      limit = list_fill;
      swapped = 1;
      while (swapped && limit > 1) begin
        swapped = 0;
        for (i = 0; i + 1 < limit; i++) begin
          if (list_due[i] > list_due[i+1]) begin
            tdue = list_due[i];
            list_due[i] = list_due[i+1];
            list_due[i+1] = tdue;
            tid = list_id[i];
            list_id[i] = list_id[i+1];
            list_id[i+1] = tid;
            swapped = 1;
          end
        end
        limit--;
      end
    endfunction

    function reply_t apply_action(logic [ACTION_W-1:0] act, logic [ID_W-1:0] id,
                                  logic [DUE_W-1:0] due, logic [POS_W-1:0] pos);
      reply_t r;
      int i;
      int hit;
      int slot;
      r.status = STATUS_OK;
      r.id = '0;
      r.due = '0;
      case (act)
        ACT_ENQUEUE: begin
          if (queue_fill >= PENDING_DEPTH) begin
            r.status = STATUS_PEND_FULL;
          end else begin
            slot = (queue_head + queue_fill) % PENDING_DEPTH;
            queue_id[slot] = id;
            queue_due[slot] = due;
            queue_fill++;
            r.id = id;
            r.due = due;
          end
        end
        ACT_PROMOTE: begin
          if (queue_fill == 0) begin
            r.status = STATUS_PEND_EMPTY;
          end else if (list_fill >= ACTIVE_DEPTH) begin
            r.status = STATUS_ACT_FULL;
          end else begin
            r.id = queue_id[queue_head];
            r.due = queue_due[queue_head];
            queue_head = (queue_head + 1) % PENDING_DEPTH;
            queue_fill--;
            for (i = list_fill; i > 0; i--) begin
              list_id[i] = list_id[i-1];
              list_due[i] = list_due[i-1];
            end
            list_id[0] = r.id;
            list_due[0] = r.due;
            list_fill++;
          end
        end
        ACT_SORT: begin
          sort_by_deadline();
        end
        ACT_COMPLETE: begin
          if (list_fill == 0) begin
            r.status = STATUS_ACT_EMPTY;
          end else begin
            hit = list_fill;
            for (i = list_fill - 1; i >= 0; i--) begin
              if (list_id[i] == id) hit = i;
            end
            if (hit >= list_fill) begin
              r.status = STATUS_NOT_FOUND;
            end else if (done_fill >= HISTORY_DEPTH) begin
              r.status = STATUS_HIST_FULL;
            end else begin
              r.id = list_id[hit];
              r.due = list_due[hit];
              for (i = hit; i + 1 < list_fill; i++) begin
                list_id[i] = list_id[i+1];
                list_due[i] = list_due[i+1];
              end
              list_fill--;
              done_id[done_fill] = r.id;
              done_fill++;
            end
          end
        end
        ACT_READ_ACTIVE: begin
          if (pos >= list_fill) begin
            r.status = STATUS_BAD_POS;
          end else begin
            r.id = list_id[pos];
            r.due = list_due[pos];
          end
        end
        ACT_READ_HISTORY: begin
          if (pos >= done_fill) begin
            r.status = STATUS_BAD_POS;
          end else begin
            r.id = done_id[done_fill - 1 - pos];
          end
        end
        default: begin
        end
      endcase
      r.pend_cnt = queue_fill[COUNT_W-1:0];
      r.act_cnt = list_fill[COUNT_W-1:0];
      r.hist_cnt = done_fill[COUNT_W-1:0];
      return r;
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      errors++;
    endtask

    function void note_request(logic [ACTION_W-1:0] act, logic [ID_W-1:0] id,
                               logic [DUE_W-1:0] due, logic [POS_W-1:0] pos);
      awaited_replies.push_back(apply_action(act, id, due, pos));
    endfunction

    task check_reply(reply_t got);
      reply_t want;
      if (awaited_replies.size() == 0) begin
        report_mismatch("unexpected transfer", got.id, 0);
        return;
      end
      want = awaited_replies.pop_front();
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.id !== want.id) report_mismatch("result_id", got.id, want.id);
      if (got.due !== want.due) report_mismatch("result_due", got.due, want.due);
      if (got.pend_cnt !== want.pend_cnt)
        report_mismatch("pending_count", got.pend_cnt, want.pend_cnt);
      if (got.act_cnt !== want.act_cnt)
        report_mismatch("active_count", got.act_cnt, want.act_cnt);
      if (got.hist_cnt !== want.hist_cnt)
        report_mismatch("history_count", got.hist_cnt, want.hist_cnt);
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [ACTION_W-1:0]    in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;

  deadline_scoreboard sb = new();
  bit steady = 0;
  int stall_cycles = 0;

  task_deadline_list_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready = steady ? 1'b1 : ($urandom_range(0, 99) >= 24);
  end

  // input transfer updates the predicted state, output transfer is checked
  always @(posedge clk) begin
    reply_t got;
    if (rst_n && in_tvalid && in_tready)
      sb.note_request(in_tuser, in_tdata[15:0], in_tdata[31:16], in_tdata[35:32]);
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.id = out_tdata[15:0];
      got.due = out_tdata[31:16];
      got.pend_cnt = out_tdata[36:32];
      got.act_cnt = out_tdata[41:37];
      got.hist_cnt = out_tdata[46:42];
      sb.check_reply(got);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(logic [ACTION_W-1:0] act, logic [ID_W-1:0] id,
                           logic [DUE_W-1:0] due, logic [POS_W-1:0] pos);
    if (!steady && $urandom_range(0, 99) < 24) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = act;
    in_tdata = IN_TDATA_W'({pos, due, id});
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic logic [ID_W-1:0] random_id();
    return ($urandom_range(0, 1) == 0) ? ID_W'($urandom_range(0, 7)) :
                                         ID_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [DUE_W-1:0] random_due();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hffff;
    if (pick < 5) return DUE_W'($urandom_range(0, 3));
    return DUE_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [POS_W-1:0] random_pos(int fill);
    if (fill > 0 && $urandom_range(0, 3) != 0) return POS_W'($urandom_range(0, fill - 1));
    return POS_W'($urandom_range(0, 15));
  endfunction

  // phases of 60 items: fill the pending queue, drain it, then a mix
  task automatic send_random_item(int n);
    int roll;
    int mode;
    int enq_w;
    int pro_w;
    logic [ID_W-1:0] id;
    mode = (n / 60) % 3;
    enq_w = (mode == 0) ? 40 : (mode == 1) ? 10 : 20;
    pro_w = (mode == 0) ? 8 : (mode == 1) ? 40 : 15;
    roll = $urandom_range(0, 99);
    id = random_id();
    if (roll < enq_w) begin
      send_item(ACT_ENQUEUE, id, random_due(), POS_W'($urandom_range(0, 15)));
    end else if (roll < enq_w + pro_w) begin
      send_item(ACT_PROMOTE, id, random_due(), POS_W'($urandom_range(0, 15)));
    end else if (roll < enq_w + pro_w + 10) begin
      send_item(ACT_SORT, id, random_due(), POS_W'($urandom_range(0, 15)));
    end else if (roll < enq_w + pro_w + 20) begin
      if (sb.list_fill > 0 && $urandom_range(0, 3) == 0)
        id = sb.list_id[$urandom_range(0, sb.list_fill - 1)];
      send_item(ACT_COMPLETE, id, random_due(), POS_W'($urandom_range(0, 15)));
    end else if (roll < 97) begin
      if ($urandom_range(0, 2) != 0)
        send_item(ACT_READ_ACTIVE, id, random_due(), random_pos(sb.list_fill));
      else
        send_item(ACT_READ_HISTORY, id, random_due(), random_pos(sb.done_fill));
    end else begin
      send_item(($urandom_range(0, 1) == 0) ? ACT_SPARE_6 : ACT_SPARE_7,
                id, random_due(), POS_W'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_item(ACT_READ_ACTIVE, 16'h0000, 16'h0000, 4'h0);
    send_item(ACT_READ_HISTORY, 16'hffff, 16'hffff, 4'h0);
    send_item(ACT_PROMOTE, 16'h0000, 16'h0000, 4'h0);
    send_item(ACT_COMPLETE, 16'h0005, 16'h0000, 4'h0);
    send_item(ACT_SORT, 16'h0000, 16'h0000, 4'h0);
    send_item(ACT_SPARE_6, 16'hffff, 16'hffff, 4'hf);
    send_item(ACT_SPARE_7, 16'h5a5a, 16'ha5a5, 4'h5);
    send_item(ACT_ENQUEUE, 16'hffff, 16'hffff, 4'hf);
    send_item(ACT_ENQUEUE, 16'h0000, 16'h0000, 4'h0);
    send_item(ACT_ENQUEUE, 16'h1234, 16'h0100, 4'h0);
    send_item(ACT_ENQUEUE, 16'h1234, 16'h0100, 4'h0);
    send_item(ACT_PROMOTE, 16'h0000, 16'h0000, 4'h0);
    send_item(ACT_SORT, 16'h0000, 16'h0000, 4'h0);
    send_item(ACT_PROMOTE, 16'h0000, 16'h0000, 4'h0);
    send_item(ACT_PROMOTE, 16'h0000, 16'h0000, 4'h0);
    send_item(ACT_PROMOTE, 16'h0000, 16'h0000, 4'h0);
    send_item(ACT_SORT, 16'h0000, 16'h0000, 4'h0);
    send_item(ACT_READ_ACTIVE, 16'h0000, 16'h0000, 4'h0);
    send_item(ACT_READ_ACTIVE, 16'h0000, 16'h0000, 4'h1);
    send_item(ACT_READ_ACTIVE, 16'h0000, 16'h0000, 4'h3);
    send_item(ACT_READ_ACTIVE, 16'h0000, 16'h0000, 4'hf);
    send_item(ACT_COMPLETE, 16'hbeef, 16'h0000, 4'h0);
    send_item(ACT_COMPLETE, 16'h1234, 16'h0000, 4'h0);
    send_item(ACT_READ_HISTORY, 16'h0000, 16'h0000, 4'h0);
    send_item(ACT_READ_HISTORY, 16'h0000, 16'h0000, 4'h1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 350 && n < 500);
      send_random_item(n);
    end
    steady = 0;
    in_tvalid = 1'b0;

    while (sb.awaited_replies.size() != 0) @(posedge clk);
    repeat (4 * ACTIVE_DEPTH) @(posedge clk);

    if (sb.errors == 0 && sb.awaited_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tdle_pkg.sv
hw/rtl/tdle_cell.sv
hw/rtl/tdle_chain.sv
hw/rtl/task_deadline_list_engine.sv
dv/task_deadline_list_engine_test.sv
